@@ sv/stpd_pkg.sv @@
`default_nettype none
package stpd_pkg;

  localparam int TIME_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int DIST_BITS = 24;
  localparam int CFG_BITS  = 32;
  localparam int QUOT_BITS = FRAC_BITS + 1;

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_WIN_START = 2'd0,
    REG_WIN_END   = 2'd1,
    REG_MODE      = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  localparam logic [DIST_BITS-1:0] DIST_ONE  = DIST_BITS'(1) << FRAC_BITS;
  localparam logic [DIST_BITS-1:0] DIST_HALF = DIST_BITS'(1) << (FRAC_BITS - 1);

endpackage
`default_nettype wire

@@ sv/stpd_train_mem.sv @@
`default_nettype none
module stpd_train_mem
  import stpd_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [TIME_BITS-1:0] wr_data,
  input  wire logic                 rd_en,
  input  wire logic [AW-1:0]        rd_addr,
  output logic      [TIME_BITS-1:0] rd_data
);

  logic [TIME_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ sv/spike_train_pair_distance.sv @@
// Spike train pair distance.
// Input channel (in_valid/in_stall, in_op, in_spike_time): op 0 appends a spike
// to train A, op 1 to train B, op 2 computes one result and clears both trains.
// A load is a single-cycle transfer and is written straight into the train memory
// unless the train is full or the time is below its last spike; then it is dropped
// and sets the load error. Result channel (out_valid/out_stall, out_distance,
// out_error_flag) carries one result per compute, held in an output register
// until the receiver takes it. A compute with an empty train, mode one or an empty
// window is answered directly. Otherwise the sequencer walks the merged grid of
// G points (at most 2*MAX_SPIKES+2); each point scans both train memories entry
// by entry, then runs the shared multiplier and the shared restoring divider.
// The block accepts no item while computing; loads are taken while a result waits,
// a further compute stalls until the result register is free.
// Reset (synchronous, active low) empties both trains, clears the load error
// and loads the window registers with 0 and all ones and the mode with 0.
`default_nettype none
module spike_train_pair_distance
  import stpd_pkg::*;
#(
  parameter int MAX_SPIKES = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_op,
  input  wire logic [TIME_BITS-1:0] in_spike_time,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [DIST_BITS-1:0] out_distance,
  output logic                      out_error_flag,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [CFG_BITS-1:0]  cfg_data
);

  localparam int AW = (MAX_SPIKES > 1) ? $clog2(MAX_SPIKES) : 1;
  localparam int CW = $clog2(MAX_SPIKES + 1);
  localparam int TB = TIME_BITS;
  localparam int PW = 2 * TB + 1;
  localparam int NW = PW + 1;
  localparam int DW = NW + FRAC_BITS;
  localparam int KW = $clog2(QUOT_BITS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SPIKES);

  typedef enum logic [3:0] {
    S_IDLE, S_PT, S_SCAN_RD, S_SCAN_EV, S_ISI, S_MUL_DEN, S_MUL_NB, S_MUL_NA,
    S_NUM, S_DIV, S_DIV_END, S_ACC_MUL, S_ACC_ADD, S_MRG_RD, S_MRG_EV
  } state_t;

  typedef enum logic [1:0] {PK_START, PK_MID, PK_END} pk_t;

  state_t state_r;
  pk_t    kind_r;

  logic [TB-1:0] ws_r, we_r;
  logic          mode_r;
  logic [CW-1:0] na_r, nb_r;
  logic [TB-1:0] last_a_r, last_b_r;
  logic          load_err_r;
  logic          out_valid_r;
  logic [DIST_BITS-1:0] dist_r;
  logic          err_r;

  logic [TB-1:0] t_r, prev_pt_r;
  logic [CW-1:0] idx_r, mia_r, mib_r;
  logic [TB-1:0] best_a_r, prev_a_r, next_a_r, best_b_r, prev_b_r, next_b_r;
  logic          got_a_r, got_b_r;
  logic [TB-1:0] isi_a_r, isi_b_r;
  logic [PW-1:0] prod_r, den_r;
  logic [NW-1:0] num_r, acc_r;
  logic [DW-1:0] n_r, dsh_r;
  logic [QUOT_BITS-1:0] q_r, s_r, s_prev_r;
  logic [KW-1:0] cnt_r;
  logic          fin_r;

  logic          accept, is_load_a, is_load_b, bad_a, bad_b, wr_a, wr_b;
  logic          rd_en;
  logic [AW-1:0] rd_addr_a, rd_addr_b;
  logic [TB-1:0] rd_a, rd_b;
  logic          empty_win;
  logic [TB:0]   isi_sum;
  logic [TB-1:0] isi_max;
  logic [TB:0]   mul_x;
  logic [TB-1:0] mul_y;
  logic [TB-1:0] d_a, d_b;
  logic          a_ok, b_ok;
  logic [TB-1:0] mrg_v;
  logic [NW-1:0] acc_sum;

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && (in_op == OP_COMPUTE));
  assign accept = in_valid && !in_stall;
  assign is_load_a = accept && (in_op == OP_LOAD_A);
  assign is_load_b = accept && (in_op == OP_LOAD_B);
  assign bad_a = (na_r == CNT_MAX) || ((na_r != '0) && (in_spike_time < last_a_r));
  assign bad_b = (nb_r == CNT_MAX) || ((nb_r != '0) && (in_spike_time < last_b_r));
  assign wr_a = is_load_a && !bad_a;
  assign wr_b = is_load_b && !bad_b;
  assign empty_win = (we_r <= ws_r);

  assign rd_en     = (state_r == S_SCAN_RD) || (state_r == S_MRG_RD);
  assign rd_addr_a = (state_r == S_SCAN_RD) ? idx_r[AW-1:0] : mia_r[AW-1:0];
  assign rd_addr_b = (state_r == S_SCAN_RD) ? idx_r[AW-1:0] : mib_r[AW-1:0];

  stpd_train_mem #(.DEPTH(MAX_SPIKES), .AW(AW)) u_mem_a (
    .clk, .wr_en(wr_a), .wr_addr(na_r[AW-1:0]), .wr_data(in_spike_time),
    .rd_en, .rd_addr(rd_addr_a), .rd_data(rd_a)
  );

  stpd_train_mem #(.DEPTH(MAX_SPIKES), .AW(AW)) u_mem_b (
    .clk, .wr_en(wr_b), .wr_addr(nb_r[AW-1:0]), .wr_data(in_spike_time),
    .rd_en, .rd_addr(rd_addr_b), .rd_data(rd_b)
  );

  assign isi_sum = {1'b0, isi_a_r} + {1'b0, isi_b_r};
  assign isi_max = (isi_a_r > isi_b_r) ? isi_a_r : isi_b_r;
  assign d_a = (rd_a > t_r) ? (rd_a - t_r) : (t_r - rd_a);
  assign d_b = (rd_b > t_r) ? (rd_b - t_r) : (t_r - rd_b);
  assign a_ok = (mia_r < na_r);
  assign b_ok = (mib_r < nb_r);
  assign mrg_v = (a_ok && b_ok) ? ((rd_a <= rd_b) ? rd_a : rd_b) : (a_ok ? rd_a : rd_b);
  assign acc_sum = acc_r + NW'(prod_r);

  always_comb begin
    unique case (state_r)
      S_MUL_DEN: begin
        mul_x = isi_sum;
        mul_y = isi_max;
      end
      S_MUL_NB: begin
        mul_x = {1'b0, isi_b_r};
        mul_y = best_b_r;
      end
      S_MUL_NA: begin
        mul_x = {1'b0, isi_a_r};
        mul_y = best_a_r;
      end
      default: begin
        mul_x = (TB + 1)'({1'b0, s_prev_r} + {1'b0, s_r});
        mul_y = t_r - prev_pt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= PK_START;
      ws_r        <= '0;
      we_r        <= '1;
      mode_r      <= 1'b0;
      na_r        <= '0;
      nb_r        <= '0;
      load_err_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fin_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_WIN_START: ws_r   <= cfg_data[TB-1:0];
          REG_WIN_END:   we_r   <= cfg_data[TB-1:0];
          REG_MODE:      mode_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (wr_a) begin
        na_r     <= na_r + 1'b1;
        last_a_r <= in_spike_time;
      end
      if (wr_b) begin
        nb_r     <= nb_r + 1'b1;
        last_b_r <= in_spike_time;
      end
      if ((is_load_a && bad_a) || (is_load_b && bad_b)) begin
        load_err_r <= 1'b1;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept && (in_op == OP_COMPUTE)) begin
            if ((na_r == '0) || (nb_r == '0) || mode_r || empty_win) begin
              if (na_r == '0 && nb_r == '0) dist_r <= '0;
              else if (na_r == '0 || nb_r == '0) dist_r <= DIST_ONE;
              else if (mode_r) dist_r <= DIST_HALF;
              else dist_r <= '0;
              err_r       <= load_err_r || empty_win;
              out_valid_r <= 1'b1;
              na_r        <= '0;
              nb_r        <= '0;
              load_err_r  <= 1'b0;
            end else begin
              acc_r   <= '0;
              fin_r   <= 1'b0;
              t_r     <= ws_r;
              kind_r  <= PK_START;
              state_r <= S_PT;
            end
          end
        end
        S_PT: begin
          idx_r    <= '0;
          best_a_r <= '1;
          best_b_r <= '1;
          prev_a_r <= ws_r;
          prev_b_r <= ws_r;
          next_a_r <= we_r;
          next_b_r <= we_r;
          got_a_r  <= 1'b0;
          got_b_r  <= 1'b0;
          state_r  <= S_SCAN_RD;
        end
        S_SCAN_RD: begin
          state_r <= ((idx_r < na_r) || (idx_r < nb_r)) ? S_SCAN_EV : S_ISI;
        end
        S_SCAN_EV: begin
          if (idx_r < na_r) begin
            if (d_a < best_a_r) best_a_r <= d_a;
            if (rd_a <= t_r) prev_a_r <= rd_a;
            else if (!got_a_r) begin
              next_a_r <= rd_a;
              got_a_r  <= 1'b1;
            end
          end
          if (idx_r < nb_r) begin
            if (d_b < best_b_r) best_b_r <= d_b;
            if (rd_b <= t_r) prev_b_r <= rd_b;
            else if (!got_b_r) begin
              next_b_r <= rd_b;
              got_b_r  <= 1'b1;
            end
          end
          idx_r   <= idx_r + 1'b1;
          state_r <= S_SCAN_RD;
        end
        S_ISI: begin
          isi_a_r <= (next_a_r >= prev_a_r) ? (next_a_r - prev_a_r) : '0;
          isi_b_r <= (next_b_r >= prev_b_r) ? (next_b_r - prev_b_r) : '0;
          state_r <= S_MUL_DEN;
        end
        S_MUL_DEN: begin
          prod_r  <= mul_x * mul_y;
          state_r <= S_MUL_NB;
        end
        S_MUL_NB: begin
          den_r   <= prod_r;
          prod_r  <= mul_x * mul_y;
          state_r <= S_MUL_NA;
        end
        S_MUL_NA: begin
          num_r   <= NW'(prod_r);
          prod_r  <= mul_x * mul_y;
          state_r <= S_NUM;
        end
        S_NUM: begin
          n_r     <= DW'(num_r + NW'(prod_r)) << FRAC_BITS;
          dsh_r   <= DW'(den_r) << FRAC_BITS;
          q_r     <= '0;
          cnt_r   <= '0;
          state_r <= (den_r == '0) ? S_DIV_END : S_DIV;
        end
        S_DIV: begin
          if (n_r >= dsh_r) begin
            n_r <= n_r - dsh_r;
          end
          q_r     <= {q_r[QUOT_BITS-2:0], (n_r >= dsh_r)};
          dsh_r   <= dsh_r >> 1;
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == KW'(QUOT_BITS - 1)) begin
            state_r <= S_DIV_END;
          end
        end
        S_DIV_END: begin
          if (fin_r) begin
            dist_r      <= DIST_BITS'(q_r);
            err_r       <= load_err_r;
            out_valid_r <= 1'b1;
            na_r        <= '0;
            nb_r        <= '0;
            load_err_r  <= 1'b0;
            state_r     <= S_IDLE;
          end else begin
            s_r <= q_r;
            if (kind_r == PK_START) begin
              s_prev_r  <= q_r;
              prev_pt_r <= ws_r;
              mia_r     <= '0;
              mib_r     <= '0;
              state_r   <= S_MRG_RD;
            end else begin
              state_r <= S_ACC_MUL;
            end
          end
        end
        S_ACC_MUL: begin
          prod_r  <= mul_x * mul_y;
          state_r <= S_ACC_ADD;
        end
        S_ACC_ADD: begin
          acc_r     <= acc_sum;
          s_prev_r  <= s_r;
          prev_pt_r <= t_r;
          if (kind_r == PK_END) begin
            n_r     <= DW'(acc_sum);
            dsh_r   <= DW'({1'b0, we_r - ws_r} << 1) << FRAC_BITS;
            q_r     <= '0;
            cnt_r   <= '0;
            fin_r   <= 1'b1;
            state_r <= S_DIV;
          end else begin
            state_r <= S_MRG_RD;
          end
        end
        S_MRG_RD: begin
          if (a_ok || b_ok) begin
            state_r <= S_MRG_EV;
          end else begin
            t_r     <= we_r;
            kind_r  <= PK_END;
            state_r <= S_PT;
          end
        end
        S_MRG_EV: begin
          if (a_ok && b_ok) begin
            if (rd_a <= rd_b) mia_r <= mia_r + 1'b1;
            if (rd_b <= rd_a) mib_r <= mib_r + 1'b1;
          end else if (a_ok) begin
            mia_r <= mia_r + 1'b1;
          end else begin
            mib_r <= mib_r + 1'b1;
          end
          if ((mrg_v > prev_pt_r) && (mrg_v < we_r)) begin
            t_r     <= mrg_v;
            kind_r  <= PK_MID;
            state_r <= S_PT;
          end else begin
            state_r <= S_MRG_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_distance   = dist_r;
  assign out_error_flag = err_r;

endmodule
`default_nettype wire
